>>> hw/rtl/ilss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilss_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // cells per registered or-group on the read path
    localparam int GROUP = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_READ   = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  word_out;
        logic [LEN_W-1:0]    length_now;
    } out_t;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic sel;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ilss_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ilss_cell #(
    parameter int WIDTH = 32
) (
    input  wire logic                clk,
    input  ilss_pkg::cell_ctrl_t     ctrl,
    input  wire logic [WIDTH-1:0]    vin,
    input  wire logic [WIDTH-1:0]    left,
    input  wire logic [WIDTH-1:0]    right,
    output logic      [WIDTH-1:0]    q,
    output logic      [WIDTH-1:0]    hit
);

    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.load)
        begin
            q_next = vin;
        end
        else if (ctrl.take_left)
        begin
            q_next = left;
        end
        else if (ctrl.take_right)
        begin
            q_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q   = q_reg;
    assign hit = ctrl.sel ? q_reg : '0;

endmodule

`default_nettype wire

>>> hw/rtl/indexed_list_shift_store_top.sv
`timescale 1ns / 1ps
`default_nettype none

// a result strobes on done once the accepted beat has passed v1_reg and then done_reg
// throughput: one beat per cycle, busy stays low; insert and remove change
//   the cells from the given position upward in the accept cycle
// the receiver cannot stall; each result is on the ports for one cycle
// reset: list length to zero, capacity_in_use to 64, no result pending;
//   entry cells are not cleared

module indexed_list_shift_store_top #(
    parameter int CAPACITY  = ilss_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ilss_pkg::WORD_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  ilss_pkg::in_t                   cmd,
    output logic                            done,
    output ilss_pkg::out_t                  result,
    input  wire logic                       cfg_we,
    input  wire logic [ilss_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int SW     = (WORD_BITS < ilss_pkg::VALUE_W) ? WORD_BITS : ilss_pkg::VALUE_W;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int W      = (CW > ilss_pkg::POS_W) ? CW : ilss_pkg::POS_W;
    localparam int NGROUP = (CAPACITY + ilss_pkg::GROUP - 1) / ilss_pkg::GROUP;

    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [ilss_pkg::CFG_W-1:0]     cfg_reg;
    logic                           v1_reg;
    logic [ilss_pkg::STATUS_W-1:0]  st1_reg;
    logic [ilss_pkg::STATUS_W-1:0]  st_next;
    logic [ilss_pkg::LEN_W-1:0]     len1_reg;
    logic [SW-1:0]                  grp_reg  [NGROUP];
    logic [SW-1:0]                  grp_next [NGROUP];
    logic                           done_reg;
    ilss_pkg::out_t                 result_reg;
    ilss_pkg::out_t                 result_next;

    logic                           accept;
    logic [W-1:0]                   limit;
    logic [W-1:0]                   posx;
    logic [W-1:0]                   cntx;
    logic                           full;
    logic                           do_app;
    logic                           do_ins;
    logic                           do_rem;
    logic                           do_clr;
    logic                           rd;
    logic [SW-1:0]                  vin;
    logic [SW-1:0]                  word_or;

    logic [SW-1:0]                  q   [CAPACITY];
    logic [SW-1:0]                  hit [CAPACITY];
    ilss_pkg::cell_ctrl_t           ctrl [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign limit = (W'(cfg_reg) > W'(CAPACITY)) ? W'(CAPACITY) : W'(cfg_reg);
    assign posx  = W'(cmd.position);
    assign cntx  = W'(count_reg);
    assign full  = (cntx >= limit);
    assign vin   = SW'(cmd.value);

    always_comb
    begin
        st_next = ilss_pkg::ST_DONE;
        do_app  = 1'b0;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_clr  = 1'b0;
        rd      = 1'b0;
        case (cmd.action)
            ilss_pkg::ACT_APPEND:
            begin
                if (full)
                begin
                    st_next = ilss_pkg::ST_FULL;
                end
                else
                begin
                    do_app = accept;
                end
            end
            ilss_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    st_next = ilss_pkg::ST_FULL;
                end
                else if (posx > cntx)
                begin
                    st_next = ilss_pkg::ST_RANGE;
                end
                else
                begin
                    do_ins = accept;
                end
            end
            ilss_pkg::ACT_READ:
            begin
                if (posx >= cntx)
                begin
                    st_next = ilss_pkg::ST_RANGE;
                end
                else
                begin
                    rd = accept;
                end
            end
            ilss_pkg::ACT_REMOVE:
            begin
                if (posx >= cntx)
                begin
                    st_next = ilss_pkg::ST_RANGE;
                end
                else
                begin
                    rd     = accept;
                    do_rem = accept;
                end
            end
            ilss_pkg::ACT_CLEAR:
            begin
                do_clr = accept;
            end
            default:
            begin
                st_next = ilss_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_app || do_ins)
        begin
            count_next = CW'(cntx + W'(1));
        end
        else if (do_rem)
        begin
            count_next = CW'(cntx - W'(1));
        end
        else if (do_clr)
        begin
            count_next = '0;
        end
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [SW-1:0] left_d;
        logic [SW-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = q[i+1];
        end

        assign ctrl[i].load       = (do_app && (W'(i) == cntx)) || (do_ins && (W'(i) == posx));
        assign ctrl[i].take_left  = do_ins && (W'(i) > posx);
        assign ctrl[i].take_right = do_rem && (W'(i) >= posx);
        assign ctrl[i].sel        = rd && (W'(i) == posx);

        ilss_cell #(
            .WIDTH (SW)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl[i]),
            .vin   (vin),
            .left  (left_d),
            .right (right_d),
            .q     (q[i]),
            .hit   (hit[i])
        );
    end

    // first read stage: or within each group of cells
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < ilss_pkg::GROUP; k++)
            begin
                if (g * ilss_pkg::GROUP + k < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | hit[g * ilss_pkg::GROUP + k];
                end
            end
        end
    end

    // second read stage: or across groups
    always_comb
    begin
        word_or = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            word_or = word_or | grp_reg[g];
        end
    end

    always_comb
    begin
        result_next.status     = st1_reg;
        result_next.word_out   = ilss_pkg::VALUE_W'(word_or);
        result_next.length_now = len1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cfg_reg   <= ilss_pkg::CFG_RESET;
            v1_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            v1_reg   <= accept;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg    <= st_next;
        len1_reg   <= ilss_pkg::LEN_W'(count_next);
        result_reg <= result_next;
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
